// ===== hdl/krt_pkg.sv =====
`default_nettype none
package krt_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int KEY_W = 31;
    localparam int YEAR_W = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOAD   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/krt_list.sv =====
`default_nettype none
// FIFO residency list: a search pass, then, on a drop or an eviction, a shift pass.
module krt_list import krt_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [6:0]       i_capacity,
    input  wire logic             i_start,
    input  wire logic             i_drop,
    input  wire logic [IDX_W-1:0] i_idx,
    output logic                  o_done,
    output logic                  o_evict,
    output logic [IDX_W-1:0]      o_evict_idx
);
    typedef enum logic [2:0] {S_IDLE, S_SRCH, S_RD, S_SHIFT, S_MOVE, S_DONE} t_state;

    logic [IDX_W-1:0] r_mem [TABLE_DEPTH];
    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_end;
    logic             r_drop;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd;
    logic             r_append;
    logic             r_evict;
    logic [IDX_W-1:0] r_evict_idx;

    function automatic logic [IDX_W-1:0] r_IDXm1(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] t;
        t = v - 1'b1;
        return t[IDX_W-1:0];
    endfunction

    assign o_done      = (r_state == S_DONE);
    assign o_evict     = r_evict;
    assign o_evict_idx = r_evict_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_evict <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_drop      <= i_drop;
                    r_idx       <= i_idx;
                    r_ptr       <= '0;
                    r_evict     <= 1'b0;
                    r_evict_idx <= '0;
                    r_state     <= S_SRCH;
                end
                // read one entry, then compare it in S_RD before reading another
                S_SRCH: begin
                    if (r_ptr >= r_count) begin
                        if (r_drop) begin
                            r_state <= S_DONE;
                        end else if ({1'b0, r_count} < {1'b0, i_capacity}
                                     && r_count < CNT_W'(TABLE_DEPTH)) begin
                            r_mem[r_count[IDX_W-1:0]] <= r_idx;
                            r_count <= r_count + 1'b1;
                            r_state <= S_DONE;
                        end else if (i_capacity != '0 && r_count != '0) begin
                            // shift out the oldest
                            r_evict     <= 1'b1;
                            r_evict_idx <= r_mem[0];
                            r_ptr       <= CNT_W'(1);
                            r_end       <= r_count;
                            r_append    <= 1'b1;
                            r_state     <= S_SHIFT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_rd    <= r_mem[r_ptr[IDX_W-1:0]];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_rd == r_idx) begin
                        if (r_drop) begin
                            r_ptr    <= r_ptr + 1'b1;
                            r_end    <= r_count;
                            r_append <= 1'b0;
                            r_count  <= r_count - 1'b1;
                            r_state  <= S_SHIFT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                // read entry ptr, then write it to ptr-1
                S_SHIFT: begin
                    if (r_ptr >= r_end) begin
                        if (r_append) r_mem[r_IDXm1(r_end)] <= r_idx;
                        r_state <= S_DONE;
                    end else begin
                        r_rd    <= r_mem[r_ptr[IDX_W-1:0]];
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_mem[r_IDXm1(r_ptr)] <= r_rd;
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= S_SHIFT;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/keyed_record_table_fifo_cache.sv =====
`default_nettype none
// Keyed record table with a FIFO residency list of up to 64 indices. One beat
// is taken at a time; o_in_ready is low while it is worked and until its result
// beat is taken. A query or delete scans the record table one record at a time.
// The residency list is searched one entry at a time and, on a delete or an
// eviction, shifted one entry at a time. Write the capacity (i_cfg_we,
// i_cfg_wdata) only while idle.
module keyed_record_table_fifo_cache import krt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [6:0]        i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_operation,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic signed [YEAR_W-1:0] i_year,
    input  wire logic              i_load_deleted,
    output logic                   o_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [KEY_W-1:0]       o_result_key,
    output logic signed [YEAR_W-1:0] o_result_year,
    output logic [IDX_W-1:0]       o_result_index,
    output logic                   o_evicted_valid,
    output logic [IDX_W-1:0]       o_evicted_index
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CMP, S_LIST, S_WAIT, S_OUT} t_state;

    logic [KEY_W-1:0]  r_keys  [TABLE_DEPTH];
    logic [YEAR_W-1:0] r_years [TABLE_DEPTH];
    logic              r_del   [TABLE_DEPTH];

    t_state            r_state;
    logic [6:0]        r_cap;
    logic [CNT_W-1:0]  r_rcount;
    logic [KEY_W-1:0]  r_next;
    logic [CNT_W-1:0]  r_ptr;
    logic [1:0]        r_op;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_rd_key;
    logic [YEAR_W-1:0] r_rd_year;
    logic              r_rd_del;
    logic              r_lstart;
    logic              r_ldrop;
    logic [IDX_W-1:0]  r_lidx;

    logic              l_done, l_evict;
    logic [IDX_W-1:0]  l_evict_idx;
    logic [KEY_W-1:0]  n_key;
    logic              n_del;

    krt_list u_list (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_capacity(r_cap),
        .i_start(r_lstart), .i_drop(r_ldrop), .i_idx(r_lidx),
        .o_done(l_done), .o_evict(l_evict), .o_evict_idx(l_evict_idx)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign n_key      = (i_operation == OP_ADD) ? r_next : i_key;
    assign n_del      = (i_operation == OP_ADD) ? 1'b0 : i_load_deleted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= '0;
            r_rcount <= '0;
            r_next   <= KEY_W'(1);
            r_lstart <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            r_lstart <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op            <= i_operation;
                    r_key           <= i_key;
                    r_ptr           <= '0;
                    o_result_key    <= '0;
                    o_result_year   <= '0;
                    o_result_index  <= '0;
                    o_evicted_valid <= 1'b0;
                    o_evicted_index <= '0;
                    if (i_operation == OP_ADD || i_operation == OP_LOAD) begin
                        if (r_rcount >= CNT_W'(TABLE_DEPTH)) begin
                            o_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_keys[r_rcount[IDX_W-1:0]]  <= n_key;
                            r_years[r_rcount[IDX_W-1:0]] <= i_year;
                            r_del[r_rcount[IDX_W-1:0]]   <= n_del;
                            r_rcount <= r_rcount + 1'b1;
                            if (i_operation == OP_ADD) r_next <= r_next + 1'b1;
                            else if (i_key >= r_next) r_next <= i_key + 1'b1;
                            o_status       <= ST_OK;
                            o_result_key   <= n_key;
                            o_result_year  <= i_year;
                            o_result_index <= r_rcount[IDX_W-1:0];
                            if (n_del) begin
                                r_state <= S_OUT;
                            end else begin
                                r_lidx   <= r_rcount[IDX_W-1:0];
                                r_ldrop  <= 1'b0;
                                r_lstart <= 1'b1;
                                r_state  <= S_LIST;
                            end
                        end
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                // record table read, one entry per visit
                S_SCAN: begin
                    if (r_ptr >= r_rcount) begin
                        o_status <= ST_NOTFOUND;
                        r_state  <= S_OUT;
                    end else begin
                        r_rd_key  <= r_keys[r_ptr[IDX_W-1:0]];
                        r_rd_year <= r_years[r_ptr[IDX_W-1:0]];
                        r_rd_del  <= r_del[r_ptr[IDX_W-1:0]];
                        r_state   <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_rd_key == r_key && !r_rd_del) begin
                        o_status       <= ST_OK;
                        o_result_key   <= r_rd_key;
                        o_result_year  <= r_rd_year;
                        o_result_index <= r_ptr[IDX_W-1:0];
                        if (r_op == OP_REMOVE) r_del[r_ptr[IDX_W-1:0]] <= 1'b1;
                        r_lidx   <= r_ptr[IDX_W-1:0];
                        r_ldrop  <= (r_op == OP_REMOVE);
                        r_lstart <= 1'b1;
                        r_state  <= S_LIST;
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_LIST: r_state <= S_WAIT;
                S_WAIT: if (l_done) begin
                    o_evicted_valid <= l_evict;
                    o_evicted_index <= l_evict ? l_evict_idx : '0;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
